// ----- src/lhem_pkg.sv -----
// Shared types, register codes and helpers for the link health escalation monitor.
`timescale 1ns / 1ps

package lhem_pkg;

  // Health classification codes
  typedef enum logic [2:0] {
    HEALTH_OK           = 3'd0,
    HEALTH_DEGRADED     = 3'd1,
    HEALTH_NO_DISCOVERY = 3'd2,
    HEALTH_NO_TRANSPORT = 3'd3,
    HEALTH_STARVING     = 3'd4
  } health_t;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_STARVE_LIMIT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_RATE     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_CANDS    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_STAGE1       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_STAGE2       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_STAGE3       = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_STAGE4       = 3'd6;

  localparam int CfgDataW = 32;
  localparam int NumStages = 4;
  // Stage threshold kept in milliseconds: 16-bit seconds times 1000 fits 26 bits
  localparam int ThrW = 26;
  localparam int StageW = 3;

  // Reset values
  localparam logic [15:0] RST_STARVE_LIMIT = 16'd3000;
  localparam logic [31:0] RST_MIN_RATE     = 32'd5120;
  localparam logic [15:0] RST_MIN_CANDS    = 16'd2;
  localparam logic [15:0] RST_STAGE1       = 16'd5;
  localparam logic [15:0] RST_STAGE2       = 16'd15;
  localparam logic [15:0] RST_STAGE3       = 16'd35;
  localparam logic [15:0] RST_STAGE4       = 16'd65;

  typedef struct packed {
    logic [15:0]                     starve_limit_ms;
    logic [31:0]                     min_rate_bytes;
    logic [15:0]                     min_candidates;
    logic [NumStages-1:0][ThrW-1:0]  stage_thr_ms;
  } cfg_t;

  typedef struct packed {
    logic        session_present;
    logic        listening;
    logic [15:0] hash_nodes;
    logic [15:0] total_peers;
    logic [15:0] cand_count;
    logic [31:0] rx_rate;
    logic        buffer_empty;
    logic [15:0] elapsed_ms;
  } tick_t;

  typedef struct packed {
    health_t           health_state;
    logic [StageW-1:0] esc_stage;
    logic [StageW-1:0] stage_fired;
    logic [31:0]       starving_time_ms;
    logic [31:0]       bad_tick_count;
  } report_t;

  // Seconds to milliseconds: v*1024 - v*16 - v*8
  function automatic logic [ThrW-1:0] sec_to_ms(input logic [15:0] v);
    logic [ThrW-1:0] x;
    x = {v, 10'b0} - {6'b0, v, 4'b0} - {7'b0, v, 3'b0};
    return x;
  endfunction

  // Saturating 32-bit add
  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ----- src/lhem_if.sv -----
// Valid/ready channel interfaces for monitor ticks and health reports.
`timescale 1ns / 1ps

interface lhem_in_if;
  logic        valid;
  logic        ready;
  logic        session_present;
  logic        listening;
  logic [15:0] hash_nodes;
  logic [15:0] total_peers;
  logic [15:0] cand_count;
  logic [31:0] rx_rate;
  logic        buffer_empty;
  logic [15:0] elapsed_ms;

  modport source (
    output valid, session_present, listening, hash_nodes, total_peers,
           cand_count, rx_rate, buffer_empty, elapsed_ms,
    input  ready
  );
  modport sink (
    input  valid, session_present, listening, hash_nodes, total_peers,
           cand_count, rx_rate, buffer_empty, elapsed_ms,
    output ready
  );
endinterface

interface lhem_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  health_state;
  logic [2:0]  esc_stage;
  logic [2:0]  stage_fired;
  logic [31:0] starving_time_ms;
  logic [31:0] bad_tick_count;

  modport source (
    output valid, health_state, esc_stage, stage_fired, starving_time_ms,
           bad_tick_count,
    input  ready
  );
  modport sink (
    input  valid, health_state, esc_stage, stage_fired, starving_time_ms,
           bad_tick_count,
    output ready
  );
endinterface

// ----- src/lhem_cfg.sv -----
// Configuration registers with stage thresholds stored in milliseconds.
`timescale 1ns / 1ps

module lhem_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [lhem_pkg::CfgIdxW-1:0]   index,
  input  logic [lhem_pkg::CfgDataW-1:0]  data,
  output lhem_pkg::cfg_t                 cfg
);
  import lhem_pkg::*;

  // Write one register; convert stage seconds to milliseconds on the way in
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.starve_limit_ms <= RST_STARVE_LIMIT;
      cfg.min_rate_bytes  <= RST_MIN_RATE;
      cfg.min_candidates  <= RST_MIN_CANDS;
      cfg.stage_thr_ms[0] <= sec_to_ms(RST_STAGE1);
      cfg.stage_thr_ms[1] <= sec_to_ms(RST_STAGE2);
      cfg.stage_thr_ms[2] <= sec_to_ms(RST_STAGE3);
      cfg.stage_thr_ms[3] <= sec_to_ms(RST_STAGE4);
    end else if (wr_en) begin
      unique case (index)
        REG_STARVE_LIMIT: cfg.starve_limit_ms <= data[15:0];
        REG_MIN_RATE:     cfg.min_rate_bytes  <= data;
        REG_MIN_CANDS:    cfg.min_candidates  <= data[15:0];
        REG_STAGE1:       cfg.stage_thr_ms[0] <= sec_to_ms(data[15:0]);
        REG_STAGE2:       cfg.stage_thr_ms[1] <= sec_to_ms(data[15:0]);
        REG_STAGE3:       cfg.stage_thr_ms[2] <= sec_to_ms(data[15:0]);
        REG_STAGE4:       cfg.stage_thr_ms[3] <= sec_to_ms(data[15:0]);
        default: ;
      endcase
    end
  end

endmodule

// ----- src/lhem_core.sv -----
// Health classification, period timers and recovery stage escalation for one tick.
`timescale 1ns / 1ps

module lhem_core (
  input  logic              clk,
  input  logic              rst,
  input  lhem_pkg::cfg_t    cfg,
  input  logic              take,
  input  lhem_pkg::tick_t   tick,
  output lhem_pkg::report_t res
);
  import lhem_pkg::*;

  logic                starving_active;
  logic [31:0]         starving_accum_ms;
  logic                bad_active;
  logic [31:0]         bad_accum_ms;
  logic [StageW-1:0]   stage_reg;
  logic [31:0]         bad_ticks_reg;

  logic                starving_active_next;
  logic [31:0]         starving_accum_ms_next;
  logic                bad_active_next;
  logic [31:0]         bad_accum_ms_next;
  logic [StageW-1:0]   stage_reg_next;
  logic [31:0]         bad_ticks_reg_next;
  health_t             health;
  logic [StageW-1:0]   fired;
  logic                found;

  always_comb begin
    // Time the empty-buffer period
    starving_active_next   = tick.buffer_empty;
    if (!tick.buffer_empty || !starving_active) begin
      starving_accum_ms_next = '0;
    end else begin
      starving_accum_ms_next = sat_add32(starving_accum_ms, {16'b0, tick.elapsed_ms});
    end

    // Classify by priority
    priority if (!tick.listening) begin
      health = HEALTH_NO_TRANSPORT;
    end else if (starving_accum_ms_next > {16'b0, cfg.starve_limit_ms}) begin
      health = HEALTH_STARVING;
    end else if (tick.hash_nodes == '0 && tick.total_peers == '0 &&
                 tick.cand_count == '0) begin
      health = HEALTH_NO_DISCOVERY;
    end else if (tick.total_peers == '0 ||
                 (tick.rx_rate < cfg.min_rate_bytes &&
                  tick.cand_count < cfg.min_candidates)) begin
      health = HEALTH_DEGRADED;
    end else begin
      health = HEALTH_OK;
    end

    // Time the bad-health period and escalate to the first higher stage whose threshold is met
    fired = '0;
    found = 1'b0;
    stage_reg_next = stage_reg;
    if (health != HEALTH_OK) begin
      bad_active_next    = 1'b1;
      bad_accum_ms_next  = bad_active ? sat_add32(bad_accum_ms, {16'b0, tick.elapsed_ms}) : '0;
      bad_ticks_reg_next = sat_add32(bad_ticks_reg, 32'd1);
      for (int k = 0; k < NumStages; k++) begin
        if (!found && bad_accum_ms_next >= {{(32-ThrW){1'b0}}, cfg.stage_thr_ms[k]} &&
            stage_reg < StageW'(k + 1)) begin
          found          = 1'b1;
          stage_reg_next = StageW'(k + 1);
          fired          = StageW'(k + 1);
        end
      end
    end else begin
      bad_active_next    = 1'b0;
      bad_accum_ms_next  = '0;
      bad_ticks_reg_next = '0;
      stage_reg_next     = '0;
    end

    // Missing session: report transport lost from held state
    if (!tick.session_present) begin
      res.health_state     = HEALTH_NO_TRANSPORT;
      res.esc_stage        = stage_reg;
      res.stage_fired      = '0;
      res.starving_time_ms = starving_accum_ms;
      res.bad_tick_count   = bad_ticks_reg;
    end else begin
      res.health_state     = health;
      res.esc_stage        = stage_reg_next;
      res.stage_fired      = fired;
      res.starving_time_ms = starving_accum_ms_next;
      res.bad_tick_count   = bad_ticks_reg_next;
    end
  end

  // Advance state when the tick moves on and a session exists
  always_ff @(posedge clk) begin
    if (rst) begin
      starving_active   <= 1'b0;
      starving_accum_ms <= '0;
      bad_active        <= 1'b0;
      bad_accum_ms      <= '0;
      stage_reg         <= '0;
      bad_ticks_reg     <= '0;
    end else if (take && tick.session_present) begin
      starving_active   <= starving_active_next;
      starving_accum_ms <= starving_accum_ms_next;
      bad_active        <= bad_active_next;
      bad_accum_ms      <= bad_accum_ms_next;
      stage_reg         <= stage_reg_next;
      bad_ticks_reg     <= bad_ticks_reg_next;
    end
  end

endmodule

// ----- src/link_health_escalation_monitor.sv -----
// Link health escalation monitor: top level with input and result registers.
// A transferred tick is held in the input register and its report in the result register.
// Throughput: one tick per cycle while reports drain; a stalled report holds the
// input register, and intake stops once both registers are full.
// State timers update as the tick leaves the input register.
// Synchronous active-high reset clears the valid flags and monitor state and loads default thresholds.
`timescale 1ns / 1ps

module link_health_escalation_monitor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [lhem_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [lhem_pkg::CfgDataW-1:0]  cfg_data,
  lhem_in_if.sink                        tick,
  lhem_out_if.source                     report
);
  import lhem_pkg::*;

  cfg_t    cfg;
  logic    s1_valid;
  tick_t   s1_item;
  logic    s1_adv;
  report_t res;
  logic    out_valid;
  report_t out_item;

  lhem_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  lhem_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .take (s1_adv),
    .tick (s1_item),
    .res  (res)
  );

  // Handshake: advance when the result register is free or being drained
  assign s1_adv     = s1_valid && (!out_valid || report.ready);
  assign tick.ready = !s1_valid || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_item.session_present <= tick.session_present;
      s1_item.listening       <= tick.listening;
      s1_item.hash_nodes      <= tick.hash_nodes;
      s1_item.total_peers     <= tick.total_peers;
      s1_item.cand_count      <= tick.cand_count;
      s1_item.rx_rate         <= tick.rx_rate;
      s1_item.buffer_empty    <= tick.buffer_empty;
      s1_item.elapsed_ms      <= tick.elapsed_ms;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item <= res;
    end
  end

  assign report.valid            = out_valid;
  assign report.health_state     = out_item.health_state;
  assign report.esc_stage        = out_item.esc_stage;
  assign report.stage_fired      = out_item.stage_fired;
  assign report.starving_time_ms = out_item.starving_time_ms;
  assign report.bad_tick_count   = out_item.bad_tick_count;

endmodule

// ----- src/lhem_checker.sv -----
// Port-level checker for the link health escalation monitor, bound to the top level.
`timescale 1ns / 1ps

module lhem_checker (
  input logic        clk,
  input logic        rst,
  input logic        rpt_valid,
  input logic        rpt_ready,
  input logic [2:0]  health_state,
  input logic [2:0]  esc_stage,
  input logic [2:0]  stage_fired,
  input logic [31:0] starving_time_ms,
  input logic [31:0] bad_tick_count
);
  import lhem_pkg::*;

  // Hold a stalled report
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rpt_valid && !rpt_ready |=> rpt_valid && $stable(health_state) &&
      $stable(esc_stage) && $stable(stage_fired) &&
      $stable(starving_time_ms) && $stable(bad_tick_count))
    else $error("report changed while stalled");

  // A fired stage is the stage now reached
  a_fired_stage: assert property (@(posedge clk) disable iff (rst)
    rpt_valid && stage_fired != 3'd0 |-> esc_stage == stage_fired)
    else $error("fired stage differs from recovery stage");

  // A healthy tick clears escalation
  a_healthy_clear: assert property (@(posedge clk) disable iff (rst)
    rpt_valid && health_state == HEALTH_OK |->
      esc_stage == 3'd0 && stage_fired == 3'd0 && bad_tick_count == 32'd0)
    else $error("healthy report with escalation state");

  // Starving implies a nonzero empty time and a counted bad tick
  a_starving_time: assert property (@(posedge clk) disable iff (rst)
    rpt_valid && health_state == HEALTH_STARVING |->
      starving_time_ms != 32'd0 && bad_tick_count != 32'd0)
    else $error("starving report without empty time");

endmodule

bind link_health_escalation_monitor lhem_checker u_lhem_checker (
  .clk              (clk),
  .rst              (rst),
  .rpt_valid        (report.valid),
  .rpt_ready        (report.ready),
  .health_state     (report.health_state),
  .esc_stage        (report.esc_stage),
  .stage_fired      (report.stage_fired),
  .starving_time_ms (report.starving_time_ms),
  .bad_tick_count   (report.bad_tick_count)
);
